// File: hdl/sialu_pkg.sv
// Shared types and codes for the signed integer ALU.
package sialu_pkg;

  localparam int unsigned DataWidth = 32;
  localparam int unsigned DivBitsPerStage = 2;
  localparam int unsigned DivStages = DataWidth / DivBitsPerStage;

  localparam logic [2:0] ModeAdd = 3'd0;
  localparam logic [2:0] ModeSub = 3'd1;
  localparam logic [2:0] ModeMul = 3'd2;
  localparam logic [2:0] ModeDiv = 3'd3;
  localparam logic [2:0] ModeRem = 3'd4;

  localparam logic [1:0] StatOk      = 2'd0;
  localparam logic [1:0] StatDivZero = 2'd1;
  localparam logic [1:0] StatModZero = 2'd2;
  localparam logic [1:0] StatBadOp   = 2'd3;

  typedef struct packed {
    logic [2:0]         mode;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] result;
    logic [1:0]         status;
  } out_word_t;

  // Per-item control carried down the pipe beside the datapath.
  typedef struct packed {
    logic [1:0]  status;
    logic        sel_div;   // selects the quotient
    logic        sel_rem;
    logic        neg_q;
    logic        neg_r;
    logic [31:0] fast;      // add / sub / mul or zero
  } ctl_t;

  // Divider work state: partial remainder, dividend/quotient shift word, divisor.
  typedef struct packed {
    logic [32:0] rem;
    logic [31:0] quo;
    logic [31:0] dvs;
  } div_t;

endpackage

// File: hdl/sialu_div_stage.sv
// One pipeline stage of the unsigned restoring divider: DivBitsPerStage quotient bits.
module sialu_div_stage (
  input  sialu_pkg::div_t din,
  output sialu_pkg::div_t dout
);
  sialu_pkg::div_t s;
  logic [32:0] t;

  always_comb begin
    s = din;
    t = '0;
    for (int k = 0; k < sialu_pkg::DivBitsPerStage; k++) begin
      t = {s.rem[31:0], s.quo[31]} - {1'b0, s.dvs};
      if (!t[32]) begin
        s.rem = t;
        s.quo = {s.quo[30:0], 1'b1};
      end else begin
        s.rem = {s.rem[31:0], s.quo[31]};
        s.quo = {s.quo[30:0], 1'b0};
      end
    end
    dout = s;
  end
endmodule

// File: hdl/sialu_front.sv
// Input decode: magnitudes, signs, status and the add/sub/mul result.
module sialu_front (
  input  sialu_pkg::in_word_t din,
  output sialu_pkg::ctl_t     ctl,
  output sialu_pkg::div_t     dstart
);
  logic [31:0] mag_a;
  logic [31:0] mag_b;
  logic [31:0] prod;
  logic        bz;

  always_comb begin
    mag_a = din.operand_a[31] ? 32'(-din.operand_a) : din.operand_a;
    mag_b = din.operand_b[31] ? 32'(-din.operand_b) : din.operand_b;
    // only the low word is kept, so a 32x32 product is enough
    prod = din.operand_a * din.operand_b;
    bz = (din.operand_b == 32'sd0);
    ctl = '0;
    ctl.neg_q = din.operand_a[31] ^ din.operand_b[31];
    ctl.neg_r = din.operand_a[31];
    unique case (din.mode)
      sialu_pkg::ModeAdd: ctl.fast = din.operand_a + din.operand_b;
      sialu_pkg::ModeSub: ctl.fast = din.operand_a - din.operand_b;
      sialu_pkg::ModeMul: ctl.fast = prod;
      sialu_pkg::ModeDiv: begin
        ctl.status = bz ? sialu_pkg::StatDivZero : sialu_pkg::StatOk;
        ctl.sel_div = !bz;
      end
      sialu_pkg::ModeRem: begin
        ctl.status = bz ? sialu_pkg::StatModZero : sialu_pkg::StatOk;
        ctl.sel_rem = !bz;
      end
      default: ctl.status = sialu_pkg::StatBadOp;
    endcase
    dstart.rem = '0;
    dstart.quo = mag_a;
    dstart.dvs = mag_b;
  end
endmodule

// File: hdl/signed_integer_alu_div_mod.sv
// Top level: pipelined signed 32-bit ALU with divide and remainder.
//
//   channel | signals                       | word
//   in      | in_valid / in_stall / in_data | sialu_pkg::in_word_t
//   out     | out_valid / out_stall / out_data | sialu_pkg::out_word_t
//
// One word per cycle when not stalled; 18 register stages: decode stage, 16
// divider stages of two quotient bits each, sign-fix/output stage. The divider
// chain sets the depth. rst clears the valid bits only. out_stall freezes the
// whole pipe while out_valid is high; in_stall is raised in exactly that case,
// so nothing is dropped or repeated.
module signed_integer_alu_div_mod (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  sialu_pkg::in_word_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output sialu_pkg::out_word_t out_data
);
  localparam int unsigned N = sialu_pkg::DivStages;

  logic                 vld  [0:N];
  sialu_pkg::ctl_t      ctl  [0:N];
  sialu_pkg::div_t      dw   [0:N];
  sialu_pkg::div_t      dnx  [0:N-1];
  sialu_pkg::ctl_t      ctl_in;
  sialu_pkg::div_t      dw_in;
  sialu_pkg::out_word_t res_next;
  logic                 adv;

  // Pipe only moves when the output side takes or is empty.
  assign adv = !(out_valid && out_stall);
  assign in_stall = !adv;

  sialu_front u_front (.din(in_data), .ctl(ctl_in), .dstart(dw_in));

  for (genvar g = 0; g < N; g++) begin : g_div
    sialu_div_stage u_stage (.din(dw[g]), .dout(dnx[g]));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctl[0] <= ctl_in;
      dw[0]  <= dw_in;
      for (int i = 0; i < N; i++) begin
        ctl[i+1] <= ctl[i];
        dw[i+1]  <= dnx[i];
      end
      out_data <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= N; i++) vld[i] <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      vld[0] <= in_valid;
      for (int i = 0; i < N; i++) vld[i+1] <= vld[i];
      out_valid <= vld[N];
    end
  end

  always_comb begin
    res_next.status = ctl[N].status;
    priority if (ctl[N].sel_div) begin
      res_next.result = ctl[N].neg_q ? 32'(-dw[N].quo) : dw[N].quo;
    end else if (ctl[N].sel_rem) begin
      res_next.result = ctl[N].neg_r ? 32'(-dw[N].rem[31:0]) : dw[N].rem[31:0];
    end else begin
      res_next.result = ctl[N].fast;
    end
  end
endmodule

// File: tb/signed_integer_alu_div_mod_test.sv
// Testbench for the signed integer ALU: random and directed words checked against a predictor.
`timescale 1ns / 1ps

module signed_integer_alu_div_mod_test;

  localparam int NumRandom = 1700;
  localparam int PipeDepth = 18;

  // Expected results for words in flight, oldest first.
  class alu_scoreboard;
    sialu_pkg::out_word_t pending[$];
    int mismatches;

    function sialu_pkg::out_word_t compute(sialu_pkg::in_word_t w);
      sialu_pkg::out_word_t r;
      logic signed [63:0] sa;
      logic signed [63:0] sb;
      logic signed [63:0] q;
      sa = w.operand_a;
      sb = w.operand_b;
      r.result = '0;
      r.status = sialu_pkg::StatOk;
      case (w.mode)
        sialu_pkg::ModeAdd: r.result = w.operand_a + w.operand_b;
        sialu_pkg::ModeSub: r.result = w.operand_a - w.operand_b;
        sialu_pkg::ModeMul: r.result = w.operand_a * w.operand_b;
        sialu_pkg::ModeDiv: begin
          if (sb == 0) r.status = sialu_pkg::StatDivZero;
          else begin
            q = sa / sb;
            r.result = q[31:0];
          end
        end
        sialu_pkg::ModeRem: begin
          if (sb == 0) r.status = sialu_pkg::StatModZero;
          else begin
            q = sa % sb;
            r.result = q[31:0];
          end
        end
        default: r.status = sialu_pkg::StatBadOp;
      endcase
      return r;
    endfunction

    function void note_input(sialu_pkg::in_word_t w);
      pending.push_back(compute(w));
    endfunction

    function void check_result(sialu_pkg::out_word_t got);
      sialu_pkg::out_word_t exp_w;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %h", got);
        return;
      end
      exp_w = pending.pop_front();
      if (got.result !== exp_w.result || got.status !== exp_w.status) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: result %h status %0d, expected %h status %0d",
                   got.result, got.status, exp_w.result, exp_w.status);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  sialu_pkg::in_word_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  sialu_pkg::out_word_t out_data;
  alu_scoreboard sb = new();
  bit driving_done = 1'b0;

  signed_integer_alu_div_mod i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always #6 clk = ~clk;

  // Holds the word on the bus until taken; valid stays up for the caller to drop.
  task automatic send_word(input sialu_pkg::in_word_t w);
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (in_stall);
    sb.note_input(w);
  endtask

  function automatic logic [31:0] rand_operand();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return $urandom_range(0, 7);
      4: return -$urandom_range(0, 7);
      default: return $urandom();
    endcase
  endfunction

  initial begin
    sialu_pkg::in_word_t w;
    sialu_pkg::in_word_t directed[$];
    logic [31:0] edges[5];
    int burst;
    int gap;
    edges = '{32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 32'h0, 32'h1};
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int m = 0; m < 8; m++) begin
      w.mode = m[2:0];
      w.operand_a = edges[m % 5];
      w.operand_b = edges[(m + 2) % 5];
      directed.push_back(w);
    end
    // divide / remainder corner cases, zero divisors included
    foreach (edges[i]) begin
      w.mode = sialu_pkg::ModeDiv; w.operand_a = edges[i]; w.operand_b = edges[(i + 2) % 5];
      directed.push_back(w);
      w.mode = sialu_pkg::ModeRem;
      directed.push_back(w);
    end
    w.mode = sialu_pkg::ModeDiv; w.operand_a = 32'h8000_0000; w.operand_b = 32'hffff_ffff;
    directed.push_back(w);
    w.mode = sialu_pkg::ModeRem;
    directed.push_back(w);
    w.mode = sialu_pkg::ModeRem; w.operand_a = -7; w.operand_b = 2;
    directed.push_back(w);
    w.mode = sialu_pkg::ModeDiv; w.operand_a = 7; w.operand_b = -2;
    directed.push_back(w);
    foreach (directed[i]) send_word(directed[i]);
    for (int n = 0; n < NumRandom; ) begin
      burst = $urandom_range(1, 40);
      for (int k = 0; k < burst && n < NumRandom; k++, n++) begin
        w.mode = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
                                             : 3'($urandom_range(0, 4));
        w.operand_a = rand_operand();
        w.operand_b = rand_operand();
        send_word(w);
      end
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b0;
    driving_done = 1'b1;
  end

  // Receiver stall: alternate free-running and choppy stretches.
  initial begin
    int phase;
    phase = 0;
    forever begin
      @(posedge clk);
      if (phase == 0) phase = $urandom_range(10, 60) * ($urandom_range(0, 1) ? 1 : -1);
      if (phase > 0) begin
        out_stall <= 1'b0;
        phase--;
      end else begin
        out_stall <= ($urandom_range(0, 2) == 0);
        phase++;
      end
    end
  end

  always @(posedge clk)
    if (!rst && out_valid && !out_stall) sb.check_result(out_data);

  initial begin
    wait (driving_done);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (PipeDepth + 4) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending.size() == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

  initial begin
    #2ms;
    $display("Simulation FAILED");
    $finish;
  end
endmodule
